// File: sv/random_permutation_shuffler_assert.svh
// ----------------------------------------------------------------------------
// random_permutation_shuffler_assert.svh
// Assertion macros shared by the shuffler checker.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PERMUTATION_SHUFFLER_ASSERT_SVH
`define RANDOM_PERMUTATION_SHUFFLER_ASSERT_SVH

// antecedent and consequent in the same cycle
`define RPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rps checker: same-cycle property failed");

// consequent in the cycle after the antecedent
`define RPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rps checker: next-cycle property failed");

`endif

// File: sv/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Types and constants of the random permutation shuffler.
// ----------------------------------------------------------------------------
package rps_pkg;

   localparam int MaxEntries = 32;
   localparam int IdxW       = $clog2(MaxEntries);
   localparam int ValW       = 6;
   localparam int CntW       = 6;
   localparam int PosW       = 5;
   localparam int WordW      = 32;

   typedef struct packed {
      logic [WordW-1:0] random_word;
      logic             rng_ok;
   } rps_req_type;

   typedef struct packed {
      logic [ValW-1:0] entry_value;
      logic [PosW-1:0] entry_position;
      logic            last_entry;
   } rps_rsp_type;

   // head of the queue between front and back
   typedef struct packed {
      logic             valid;
      logic [WordW-1:0] word;
   } rps_queue_type;

   typedef struct packed {
      logic             start;
      logic [WordW-1:0] dividend;
      logic [CntW-1:0]  divisor;
   } rps_div_req_type;

   typedef struct packed {
      logic            done;
      logic [CntW-1:0] remainder;
   } rps_div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_WR_POS,
      ST_WR_J,
      ST_EMIT_RD,
      ST_EMIT_LD
   } rps_state_type;

   // clamp the count register to 1..MaxEntries
   function automatic logic [CntW-1:0] active_count(input logic [CntW-1:0] cnt);
      logic [CntW-1:0] res;
      res = cnt;
      if (cnt == '0) begin
         res = CntW'(1);
      end else if (cnt > CntW'(MaxEntries)) begin
         res = CntW'(MaxEntries);
      end
      return res;
   endfunction

endpackage

// File: sv/rps_front.sv
// ----------------------------------------------------------------------------
// rps_front
// Accepts request beats, zeroes failed random words and queues them (2 deep).
// ----------------------------------------------------------------------------
module rps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rps_pkg::rps_req_type req_data,
   output rps_pkg::rps_queue_type q_head,
   input  logic                q_pop
);
   import rps_pkg::*;

   logic [WordW-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;
   logic             pop;
   logic [WordW-1:0] clean_word;

   assign req_ready  = (fill_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign pop        = q_pop && (fill_ff != 2'd0);
   assign clean_word = req_data.rng_ok ? req_data.random_word : '0;

   assign q_head.valid = (fill_ff != 2'd0);
   assign q_head.word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= clean_word;
      end
   end

endmodule

// File: sv/rps_div.sv
// ----------------------------------------------------------------------------
// rps_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rps_div (
   input  logic                    clock,
   input  logic                    reset,
   input  rps_pkg::rps_div_req_type div_req,
   output rps_pkg::rps_div_rsp_type div_rsp
);
   import rps_pkg::*;

   localparam int StepW = $clog2(WordW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [WordW-1:0] quo_ff, quo_in;
   logic [CntW-1:0]  rem_ff, rem_in;
   logic [CntW-1:0]  dvs_ff, dvs_in;
   logic [CntW:0]    trial;

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[WordW-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WordW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CntW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = CntW'(trial);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(WordW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// File: sv/rps_back.sv
// ----------------------------------------------------------------------------
// rps_back
// Swap sequencer, permutation table and response register.
// ----------------------------------------------------------------------------
module rps_back (
   input  logic                     clock,
   input  logic                     reset,
   input  rps_pkg::rps_queue_type   q_head,
   output logic                     q_pop,
   output rps_pkg::rps_div_req_type div_req,
   input  rps_pkg::rps_div_rsp_type div_rsp,
   input  logic                     csr_wr_en,
   input  logic [rps_pkg::CntW-1:0] csr_wr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rps_pkg::rps_rsp_type     rsp_data
);
   import rps_pkg::*;

   rps_state_type   state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic [IdxW-1:0] j_ff, j_in;
   logic [IdxW-1:0] k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rps_rsp_type     rsp_ff, rsp_in;
   logic            load;

   logic [ValW-1:0]       mem_ff [MaxEntries];
   logic [MaxEntries-1:0] vld_ff;
   logic [ValW-1:0]       rda_ff, rdb_ff;
   logic [IdxW-1:0]       addr_a;
   logic                  we;
   logic [IdxW-1:0]       waddr;
   logic [ValW-1:0]       wdata;
   logic                  clr;

   logic [CntW-1:0] act;
   logic [CntW-1:0] new_act;

   assign act       = active_count(count_ff);
   assign new_act   = active_count(csr_wr_data);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign addr_a    = (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) ? k_ff : pos_ff;

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      j_in             = j_ff;
      k_in             = k_ff;
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_head.word;
      div_req.divisor  = CntW'(pos_ff) + CntW'(1);
      we               = 1'b0;
      waddr            = pos_ff;
      wdata            = rdb_ff;
      clr              = 1'b0;
      load             = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in.entry_value    = rda_ff;
      rsp_in.entry_position = PosW'(k_ff);
      rsp_in.last_entry     = (CntW'(k_ff) == act - CntW'(1));

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (act > CntW'(1)) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  k_in     = '0;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               j_in     = IdxW'(div_rsp.remainder);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_WR_POS;
         end
         ST_WR_POS: begin
            we       = 1'b1;
            waddr    = pos_ff;
            wdata    = rdb_ff;
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            // read regs still hold the pre-swap entry at pos
            we     = 1'b1;
            waddr  = j_ff;
            wdata  = rda_ff;
            pos_in = pos_ff - 1'b1;
            if (pos_ff == IdxW'(1)) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               if (rsp_in.last_entry) begin
                  clr      = 1'b1;
                  pos_in   = IdxW'(act - CntW'(1));
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // count write restarts the pass
      if (csr_wr_en) begin
         count_in = csr_wr_data;
         clr      = 1'b1;
         pos_in   = IdxW'(new_act - CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CntW'(MaxEntries);
         pos_ff       <= IdxW'(MaxEntries - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      k_ff <= k_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // unwritten entries read as the identity
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rda_ff <= vld_ff[addr_a] ? mem_ff[addr_a] : ValW'(addr_a) + ValW'(1);
      rdb_ff <= vld_ff[j_ff] ? mem_ff[j_ff] : ValW'(j_ff) + ValW'(1);
   end

endmodule

// File: sv/random_permutation_shuffler.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// Fisher-Yates shuffle of 1..count, one swap per random word when count exceeds 1.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | random_word, rng_ok
//  rsp     | out | rsp_valid/ready    | entry_value, entry_position, last_entry
//  csr     | in  | csr_wr_en          | entry_count
//
// A swap is a queue pop, a pass through the bit-serial remainder unit,
// then a table read and two single-port writes.
// The last word of a pass then emits every entry, each through a registered table read.
// With count 1 each word gives one beat.
// Reset is immediate: per-entry valid bits make the table read as the identity.
// The two-deep request queue and the response register let either side stall.
// ----------------------------------------------------------------------------
module random_permutation_shuffler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rps_pkg::rps_req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rps_pkg::rps_rsp_type     rsp_data,
   input  logic                     csr_wr_en,
   input  logic [rps_pkg::CntW-1:0] csr_wr_data
);
   import rps_pkg::*;

   rps_queue_type   q_head;
   logic            q_pop;
   rps_div_req_type div_req;
   rps_div_rsp_type div_rsp;

   rps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   rps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// File: sv/rps_checker.sv
// ----------------------------------------------------------------------------
// rps_checker
// Port-level checks on the shuffler response channel.
// ----------------------------------------------------------------------------
`include "random_permutation_shuffler_assert.svh"

module rps_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rps_pkg::rps_rsp_type rsp_data
);
   import rps_pkg::*;

   `RPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `RPS_ASSERT_SAME(a_value_range, clock, reset, rsp_valid, rsp_data.entry_value != '0 && rsp_data.entry_value <= ValW'(MaxEntries))
   `RPS_ASSERT_SAME(a_top_is_last, clock, reset, rsp_valid && rsp_data.entry_position == PosW'(MaxEntries - 1), rsp_data.last_entry)

endmodule

bind random_permutation_shuffler rps_checker u_rps_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
